// File: rtl/frequency_ordered_list_macros.svh
// Assertion macros used by the checker file of the frequency ordered list.
`ifndef FREQUENCY_ORDERED_LIST_MACROS_SVH
`define FREQUENCY_ORDERED_LIST_MACROS_SVH

// Property checked on every clock edge outside reset.
`define FOL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("frequency_ordered_list: assertion failed");

// Property checked on every clock edge, reset included.
`define FOL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("frequency_ordered_list: assertion failed");

`endif

// File: rtl/fol_pkg.sv
// Package: codes and default sizes for the frequency ordered list.
`timescale 1ns / 1ps

package fol_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int MODE_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 16;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOCATE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

endpackage

// File: rtl/frequency_ordered_list.sv
// Top level: count-ordered self-organizing table with a scan/shift sequencer.
// Sequence: clear, append, full and unused mode go straight to the output stage; a locate
// reads and compares entries from the head; on a hit, earlier entries shift back until
// a greater count stops it. Results wait while out_stall holds. One table read a step.
// Throughput: one item at a time; the next item is taken the cycle after the result loads.
// Reset: synchronous, active high; empties the table and drops any pending result.
`timescale 1ns / 1ps

module frequency_ordered_list #(
  parameter int DEPTH       = fol_pkg::DEPTH_DEF,
  parameter int COUNT_WIDTH = fol_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [fol_pkg::MODE_W-1:0]         mode,
  input  logic signed [fol_pkg::VALUE_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [fol_pkg::STATUS_W-1:0]       status,
  output logic [fol_pkg::POS_W-1:0]          position,
  output logic [fol_pkg::COUNT_W-1:0]        count
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int USE_W = $clog2(DEPTH + 1);
  localparam int VW    = fol_pkg::VALUE_W;
  localparam int PW    = (IDX_W > fol_pkg::POS_W) ? IDX_W : fol_pkg::POS_W;
  localparam int CW    = (COUNT_WIDTH > fol_pkg::COUNT_W) ? COUNT_WIDTH : fol_pkg::COUNT_W;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN_RD  = 3'd1;
  localparam logic [2:0] S_SCAN_CMP = 3'd2;
  localparam logic [2:0] S_MOVE_RD  = 3'd3;
  localparam logic [2:0] S_MOVE_CMP = 3'd4;
  localparam logic [2:0] S_FINAL    = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0]             state;
  logic [USE_W-1:0]       used;
  logic [IDX_W-1:0]       idx;
  logic [VW-1:0]          key;
  logic [COUNT_WIDTH-1:0] hit_cnt;

  logic [fol_pkg::STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]             res_pos;
  logic [COUNT_WIDTH-1:0]       res_cnt;

  // table memory: one write and one registered read per cycle
  logic [VW-1:0]          mem_val [DEPTH];
  logic [COUNT_WIDTH-1:0] mem_cnt [DEPTH];
  logic [IDX_W-1:0]       rd_addr;
  logic [VW-1:0]          rd_val;
  logic [COUNT_WIDTH-1:0] rd_cnt;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [VW-1:0]          wr_val;
  logic [COUNT_WIDTH-1:0] wr_cnt;

  logic                   accept;
  logic                   full;
  logic                   scan_last;
  logic [IDX_W-1:0]       idx_prev;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   out_free;
  logic [PW-1:0]          pos_wide;
  logic [CW-1:0]          cnt_wide;

  assign in_stall  = rst || (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign full      = (used == USE_W'(DEPTH));
  assign scan_last = ((USE_W'(idx) + USE_W'(1)) == used);
  assign idx_prev  = idx - IDX_W'(1);
  assign cnt_inc   = (rd_cnt == {COUNT_WIDTH{1'b1}}) ? rd_cnt : rd_cnt + COUNT_WIDTH'(1);
  assign out_free  = !out_valid || !out_stall;
  assign pos_wide  = PW'(res_pos);
  assign cnt_wide  = CW'(res_cnt);

  always_comb begin
    rd_addr = idx;
    if (state == S_MOVE_RD) begin
      rd_addr = idx_prev;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_val  = key;
    wr_cnt  = hit_cnt;
    case (state)
      S_IDLE: begin
        if (accept && mode == fol_pkg::MODE_APPEND && !full) begin
          wr_en   = 1'b1;
          wr_addr = used[IDX_W-1:0];
          wr_val  = $unsigned(value);
          wr_cnt  = '0;
        end
      end
      S_MOVE_CMP: begin
        // shift the earlier entry one place toward the tail
        if (rd_cnt <= hit_cnt) begin
          wr_en  = 1'b1;
          wr_val = rd_val;
          wr_cnt = rd_cnt;
        end
      end
      S_FINAL: begin
        wr_en = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_val[wr_addr] <= wr_val;
      mem_cnt[wr_addr] <= wr_cnt;
    end
    rd_val <= mem_val[rd_addr];
    rd_cnt <= mem_cnt[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_pos <= '0;
            res_cnt <= '0;
            state   <= S_DONE;
            case (mode)
              fol_pkg::MODE_CLEAR: begin
                used       <= '0;
                res_status <= fol_pkg::ST_CLEARED;
              end
              fol_pkg::MODE_APPEND: begin
                if (full) begin
                  res_status <= fol_pkg::ST_FULL;
                end else begin
                  used       <= used + USE_W'(1);
                  res_status <= fol_pkg::ST_APPENDED;
                  res_pos    <= used[IDX_W-1:0];
                end
              end
              fol_pkg::MODE_LOCATE: begin
                res_status <= fol_pkg::ST_MISS;
                idx        <= '0;
                key        <= $unsigned(value);
                if (used != '0) begin
                  state <= S_SCAN_RD;
                end
              end
              default: begin
                res_status <= fol_pkg::ST_MISS;
              end
            endcase
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if (rd_val == key) begin
            hit_cnt <= cnt_inc;
            state   <= (idx == '0) ? S_FINAL : S_MOVE_RD;
          end else if (scan_last) begin
            state <= S_DONE;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_SCAN_RD;
          end
        end
        S_MOVE_RD: begin
          state <= S_MOVE_CMP;
        end
        S_MOVE_CMP: begin
          if (rd_cnt <= hit_cnt) begin
            idx   <= idx_prev;
            state <= (idx_prev == '0) ? S_FINAL : S_MOVE_RD;
          end else begin
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          res_status <= fol_pkg::ST_FOUND;
          res_pos    <= idx;
          res_cnt    <= hit_cnt;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register: load a staged result when the slot frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
      status    <= res_status;
      position  <= pos_wide[fol_pkg::POS_W-1:0];
      count     <= cnt_wide[fol_pkg::COUNT_W-1:0];
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/fol_checker.sv
// Checker: port-level properties of the frequency ordered list, bound to the top level.
`timescale 1ns / 1ps
`include "frequency_ordered_list_macros.svh"

module fol_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [fol_pkg::STATUS_W-1:0] status,
  input logic [fol_pkg::POS_W-1:0]    position,
  input logic [fol_pkg::COUNT_W-1:0]  count
);

  logic in_take;
  logic plain_result;
  logic plain_zero;
  logic out_held;
  assign in_take      = in_valid && !in_stall;
  assign plain_result = out_valid && status != fol_pkg::ST_FOUND
                        && status != fol_pkg::ST_APPENDED;
  assign plain_zero   = (position == '0) && (count == '0);
  assign out_held     = out_valid && out_stall;

  `FOL_ASSERT_ALWAYS(a_reset_empties_output, rst |=> !out_valid)
  `FOL_ASSERT(a_busy_after_accept, in_take |=> in_stall)
  `FOL_ASSERT(a_status_known, out_valid |-> status <= fol_pkg::ST_CLEARED)
  `FOL_ASSERT(a_plain_results_zero, plain_result |-> plain_zero)
  `FOL_ASSERT(a_stalled_result_holds, out_held |=> (out_valid && $stable({status, position, count})))

endmodule

bind frequency_ordered_list fol_checker u_fol_checker (.*);

// File: sim/tb_frequency_ordered_list.sv
// Testbench for the frequency ordered list: predicts every result and checks it.
`timescale 1ns / 1ps

module tb_frequency_ordered_list;
  import fol_pkg::*;

  localparam int TABLE_DEPTH = DEPTH_DEF;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOT_HITS = 20;
  localparam longint LIMIT_CYCLES = 12_000_000;
  localparam logic [VALUE_W-1:0] HOT_VALUE = 32'h5A5A_A5A5;
  localparam logic [VALUE_W-1:0] HOT_OTHER = 32'hC3C3_3C3C;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  cnt;
  } fol_result_t;

  class fol_scoreboard;
    logic [VALUE_W-1:0] entry_val[TABLE_DEPTH];
    logic [COUNT_W-1:0] entry_cnt[TABLE_DEPTH];
    int unsigned n_used;
    fol_result_t due_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned by_status[8];
    logic [COUNT_W-1:0] peak_count;

    function new();
      n_used = 0;
      errors = 0;
      checked = 0;
      peak_count = '0;
      foreach (by_status[i]) by_status[i] = 0;
    endfunction

    // Work out the result of one accepted item and advance the table copy.
    function void note_item(input logic [MODE_W-1:0] m, input logic [VALUE_W-1:0] v);
      fol_result_t r;
      int hit;
      int dst;
      int i;
      int k;
      logic [COUNT_W-1:0] c;
      r = '0;
      r.status = ST_MISS;
      hit = -1;
      case (m)
        MODE_CLEAR: begin
          n_used = 0;
          r.status = ST_CLEARED;
        end
        MODE_APPEND: begin
          if (n_used >= TABLE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            entry_val[n_used] = v;
            entry_cnt[n_used] = '0;
            r.status = ST_APPENDED;
            r.position = n_used[POS_W-1:0];
            n_used++;
          end
        end
        MODE_LOCATE: begin
          for (i = 0; i < n_used; i++) begin
            if (hit < 0 && entry_val[i] == v) hit = i;
          end
          if (hit >= 0) begin
            c = entry_cnt[hit];
            if (c != COUNT_MAX) c++;
            // stop just behind the nearest earlier entry with a greater count
            dst = hit;
            while (dst > 0 && entry_cnt[dst-1] <= c) dst--;
            for (k = hit; k > dst; k--) begin
              entry_val[k] = entry_val[k-1];
              entry_cnt[k] = entry_cnt[k-1];
            end
            entry_val[dst] = v;
            entry_cnt[dst] = c;
            r.status = ST_FOUND;
            r.position = dst[POS_W-1:0];
            r.cnt = c;
          end
        end
        default: ;  // unused mode reports a miss
      endcase
      due_q.push_back(r);
    endfunction

    function void report(input string field, input int unsigned want, input int unsigned got);
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_result(input logic [STATUS_W-1:0] s, input logic [POS_W-1:0] p,
                               input logic [COUNT_W-1:0] c);
      fol_result_t want;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: result mismatch: expected none, actual status %0d position %0d count %0d",
                 $time, s, p, c);
        return;
      end
      want = due_q.pop_front();
      checked++;
      by_status[want.status]++;
      if (want.cnt > peak_count) peak_count = want.cnt;
      if (s !== want.status) report("status", want.status, s);
      if (p !== want.position) report("position", want.position, p);
      if (c !== want.cnt) report("count", want.cnt, c);
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [MODE_W-1:0]         mode = MODE_CLEAR;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [STATUS_W-1:0]       status;
  logic [POS_W-1:0]          position;
  logic [COUNT_W-1:0]        count;

  fol_scoreboard sb;
  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned items_sent = 0;
  logic [VALUE_W-1:0] appended[$];

  frequency_ordered_list uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .position(position),
    .count(count)
  );

  always #5 clk = ~clk;

  // Receiver: random stall bursts, plus a long hold-off on request.
  initial begin
    int unsigned served;
    int stall_left;
    served = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != served) begin
        served = hold_requests;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      sb.check_result(status, position, count);
    end
  end

  initial begin
    longint cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycles);
    $display("end of test: mismatches");
    $finish;
  end

  task automatic offer(input logic [MODE_W-1:0] m, input logic [VALUE_W-1:0] v);
    int gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    mode <= m;
    value <= v;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_item(m, v);
    items_sent++;
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2: return $urandom_range(0, 7);  // small pool, so duplicates show up
      default: return $urandom();
    endcase
  endfunction

  // One burst of work: optional clear, a run of appends, then mostly hits.
  task automatic random_episode();
    int n_app;
    int n_loc;
    int k;
    int pick;
    logic [VALUE_W-1:0] v;
    if ($urandom_range(0, 3) != 0) begin
      offer(MODE_CLEAR, pick_value());
      appended.delete();
    end
    n_app = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 19) : $urandom_range(1, 12);
    for (k = 0; k < n_app; k++) begin
      v = pick_value();
      offer(MODE_APPEND, v);
      if (appended.size() < TABLE_DEPTH) appended.push_back(v);
    end
    n_loc = $urandom_range(8, 40);
    for (k = 0; k < n_loc; k++) begin
      pick = $urandom_range(0, 19);
      if (pick < 16 && appended.size() > 0) begin
        // favor entries appended early so counts spread apart
        offer(MODE_LOCATE, appended[$urandom_range(0, $urandom_range(0, appended.size() - 1))]);
      end else if (pick < 18) begin
        offer(MODE_LOCATE, pick_value());
      end else if (pick == 18) begin
        offer(MODE_UNUSED, pick_value());
      end else if ($urandom_range(0, 1) == 0) begin
        v = pick_value();
        offer(MODE_APPEND, v);
        if (appended.size() < TABLE_DEPTH) appended.push_back(v);
      end else begin
        offer(MODE_CLEAR, pick_value());
        appended.delete();
      end
    end
  endtask

  initial begin
    int k;
    int episode;
    int unsigned base;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes, full table, unused mode
    offer(MODE_LOCATE, 32'h0000_0000);
    offer(MODE_UNUSED, 32'hFFFF_FFFF);
    offer(MODE_CLEAR, 32'h0000_0000);
    offer(MODE_APPEND, 32'h8000_0000);
    offer(MODE_APPEND, 32'h7FFF_FFFF);
    offer(MODE_APPEND, 32'h0000_0000);
    offer(MODE_APPEND, 32'hFFFF_FFFF);
    for (k = 4; k < TABLE_DEPTH; k++) offer(MODE_APPEND, 32'h0001_0000 * k + k);
    offer(MODE_APPEND, 32'h1234_5678);
    offer(MODE_LOCATE, 32'h0001_0000 * (TABLE_DEPTH - 1) + (TABLE_DEPTH - 1));
    offer(MODE_LOCATE, 32'h1234_5678);
    offer(MODE_LOCATE, 32'h7FFF_FFFF);
    offer(MODE_UNUSED, 32'h8000_0000);
    offer(MODE_CLEAR, 32'hFFFF_FFFF);
    offer(MODE_LOCATE, 32'h7FFF_FFFF);
    drain();

    // raise one count at the head, then hit a second entry behind it
    offer(MODE_CLEAR, 32'h0000_0000);
    offer(MODE_APPEND, HOT_VALUE);
    offer(MODE_APPEND, HOT_OTHER);
    repeat (HOT_HITS) offer(MODE_LOCATE, HOT_VALUE);
    offer(MODE_LOCATE, HOT_OTHER);
    offer(MODE_CLEAR, 32'h0000_0000);
    drain();

    // random part with idling, long receiver hold-offs and periodic pauses
    base = items_sent;
    episode = 0;
    while (items_sent < base + 1100) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      if (episode == 6 || episode == 20) hold_requests++;
      random_episode();
      if (episode % 5 == 4) drain();
      episode++;
    end

    // last stretch runs at full rate
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    while (items_sent < base + 1600) random_episode();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d items, %0d results checked, incl. a run of hits on one entry.",
             items_sent, sb.checked);
    $display("Found %0d, not found %0d, appended %0d, full %0d, cleared %0d; top count %0d.",
             sb.by_status[ST_FOUND], sb.by_status[ST_MISS], sb.by_status[ST_APPENDED],
             sb.by_status[ST_FULL], sb.by_status[ST_CLEARED], sb.peak_count);
    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
